/* hw/rtl/chsd_pkg.sv */
// Package: shared types and constants for the shard directory.
`timescale 1ns / 1ps
`default_nettype none
package chsd_pkg;
    localparam logic [1:0] OP_REGISTER  = 2'd0;
    localparam logic [1:0] OP_HEARTBEAT = 2'd1;
    localparam logic [1:0] OP_DISCOVER  = 2'd2;
    localparam logic [1:0] OP_SWEEP     = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    localparam logic [0:0] CFG_MAX_ENTRIES = 1'b0;
    localparam logic [0:0] CFG_LIFETIME    = 1'b1;

    localparam int ID_W   = 31;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int TIME_W = 32;
    localparam int ENT_W  = ID_W + ADDR_W + PORT_W + TIME_W;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] addr;
        logic [ID_W-1:0]   id;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic do_insert;
        logic do_renew;
        logic do_sweep;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       any_hit;
        logic       empty;
        logic       full;
    } t_stat;
endpackage
`default_nettype wire

/* hw/rtl/chsd_datapath.sv */
// Datapath: sorted cell array with parallel compare, insert shift and compaction.
`timescale 1ns / 1ps
`default_nettype none
module chsd_datapath #(
    parameter int CAPACITY = 128
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire chsd_pkg::t_cmd               i_cmd,
    input  wire logic [chsd_pkg::ID_W-1:0]    i_id,
    input  wire logic [chsd_pkg::ADDR_W-1:0]  i_addr,
    input  wire logic [chsd_pkg::PORT_W-1:0]  i_port,
    input  wire logic [chsd_pkg::ID_W-1:0]    i_key,
    input  wire logic [chsd_pkg::TIME_W-1:0]  i_now,
    input  wire logic [chsd_pkg::TIME_W-1:0]  i_expiry,
    input  wire logic [$clog2(CAPACITY+1)-1:0] i_limit,
    output chsd_pkg::t_stat                   o_stat,
    output chsd_pkg::t_entry                  o_found,
    output logic [7:0]                        o_removed
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    chsd_pkg::t_entry r_cell [CAPACITY];
    chsd_pkg::t_entry n_cell [CAPACITY];
    logic [CW-1:0]    r_count, n_count;

    logic [CAPACITY-1:0] live, le_id, le_key, hit, dead;
    logic [CW-1:0]       ins_pos, key_pos;
    // running count of expired cells, level l sums windows of 2**l cells
    logic [CW-1:0]       dead_sum [IW+1][CAPACITY];
    logic [CW-1:0]       dead_total;
    // compaction network: stage b has moved each kept cell down by its low b shift bits
    chsd_pkg::t_entry    cmp_cell [IW+1][CAPACITY];
    logic [CW-1:0]       cmp_sh   [IW+1][CAPACITY];
    logic                cmp_vld  [IW+1][CAPACITY];

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            live[i]   = CW'(i) < r_count;
            le_id[i]  = live[i] && (r_cell[i].id <= i_id);
            le_key[i] = live[i] && (r_cell[i].id <= i_key);
            hit[i]    = live[i] && (r_cell[i].id == i_id);
            dead[i]   = live[i] && (r_cell[i].expiry < i_now);
        end
        // sorted order: compare bits form a run of ones, position is its first zero
        ins_pos = CW'(CAPACITY);
        key_pos = CW'(CAPACITY);
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!le_id[i])
                ins_pos = CW'(i);
            if (!le_key[i])
                key_pos = CW'(i);
        end
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++)
            dead_sum[0][i] = CW'(dead[i]);
        for (int l = 0; l < IW; l++)
            for (int i = 0; i < CAPACITY; i++)
                if (i >= (1 << l))
                    dead_sum[l+1][i] = dead_sum[l][i] + dead_sum[l][i - (1 << l)];
                else
                    dead_sum[l+1][i] = dead_sum[l][i];
        dead_total = dead_sum[IW][CAPACITY-1];
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cmp_cell[0][i] = r_cell[i];
            cmp_sh[0][i]   = dead_sum[IW][i];
            cmp_vld[0][i]  = live[i] && !dead[i];
        end
        for (int b = 0; b < IW; b++)
            for (int p = 0; p < CAPACITY; p++) begin
                cmp_cell[b+1][p] = cmp_cell[b][p];
                cmp_sh[b+1][p]   = cmp_sh[b][p];
                cmp_vld[b+1][p]  = cmp_vld[b][p] && !cmp_sh[b][p][b];
                if (p + (1 << b) < CAPACITY) begin
                    if (cmp_vld[b][p + (1 << b)] && cmp_sh[b][p + (1 << b)][b]) begin
                        cmp_cell[b+1][p] = cmp_cell[b][p + (1 << b)];
                        cmp_sh[b+1][p]   = cmp_sh[b][p + (1 << b)];
                        cmp_vld[b+1][p]  = 1'b1;
                    end
                end
            end
    end

    always_comb begin
        o_stat.any_hit = |hit;
        o_stat.empty   = (r_count == '0);
        o_stat.full    = (r_count >= i_limit);
        if (key_pos >= r_count)
            o_found = r_cell[0];
        else
            o_found = r_cell[key_pos[IW-1:0]];
        o_removed = 8'(dead_total);
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++)
            n_cell[i] = r_cell[i];
        n_count = r_count;
        if (i_cmd.do_insert) begin
            for (int i = 1; i < CAPACITY; i++)
                if (CW'(i) > ins_pos)
                    n_cell[i] = r_cell[i-1];
            n_cell[ins_pos[IW-1:0]] = '{expiry: i_expiry, port: i_port,
                                        addr: i_addr, id: i_id};
            n_count = r_count + 1'b1;
        end else if (i_cmd.do_renew) begin
            for (int i = 0; i < CAPACITY; i++)
                if (hit[i])
                    n_cell[i].expiry = i_expiry;
        end else if (i_cmd.do_sweep) begin
            for (int i = 0; i < CAPACITY; i++)
                if (cmp_vld[IW][i])
                    n_cell[i] = cmp_cell[IW][i];
            n_count = r_count - dead_total;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CAPACITY; i++)
            r_cell[i] <= n_cell[i];
        if (!i_rst_n)
            r_count <= '0;
        else
            r_count <= n_count;
    end
endmodule
`default_nettype wire

/* hw/rtl/chsd_ctrl.sv */
// Controller: accepts one request, issues the datapath command, forms the result.
`timescale 1ns / 1ps
`default_nettype none
module chsd_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_req_valid,
    output logic                              o_req_ready,
    input  wire logic [1:0]                   i_op,
    input  wire chsd_pkg::t_stat              i_stat,
    input  wire chsd_pkg::t_entry             i_found,
    input  wire logic [7:0]                   i_removed,
    output chsd_pkg::t_cmd                    o_cmd,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output logic [1:0]                        o_status,
    output logic [chsd_pkg::ID_W-1:0]         o_fid,
    output logic [chsd_pkg::ADDR_W-1:0]       o_faddr,
    output logic [chsd_pkg::PORT_W-1:0]       o_fport,
    output logic [7:0]                        o_removed
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_HOLD = 1'b1;

    logic r_state;
    logic take;

    logic [1:0]                  r_status;
    logic [chsd_pkg::ID_W-1:0]   r_fid;
    logic [chsd_pkg::ADDR_W-1:0] r_faddr;
    logic [chsd_pkg::PORT_W-1:0] r_fport;
    logic [7:0]                  r_removed;

    assign o_req_ready = (r_state == S_IDLE) || i_res_ready;
    assign take        = i_req_valid && o_req_ready;
    assign o_res_valid = (r_state == S_HOLD);

    assign o_status  = r_status;
    assign o_fid     = r_fid;
    assign o_faddr   = r_faddr;
    assign o_fport   = r_fport;
    assign o_removed = r_removed;

    always_comb begin
        o_cmd.do_insert = take && (i_op == chsd_pkg::OP_REGISTER) && !i_stat.full;
        o_cmd.do_renew  = take && (i_op == chsd_pkg::OP_HEARTBEAT) && i_stat.any_hit;
        o_cmd.do_sweep  = take && (i_op == chsd_pkg::OP_SWEEP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else if (take) begin
            r_state <= S_HOLD;
        end else if (i_res_ready) begin
            r_state <= S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_status  <= chsd_pkg::ST_OK;
            r_fid     <= '0;
            r_faddr   <= '0;
            r_fport   <= '0;
            r_removed <= '0;
            unique case (i_op)
                chsd_pkg::OP_REGISTER:
                    if (i_stat.full) r_status <= chsd_pkg::ST_FULL;
                chsd_pkg::OP_HEARTBEAT:
                    if (!i_stat.any_hit) r_status <= chsd_pkg::ST_NOT_FOUND;
                chsd_pkg::OP_DISCOVER: begin
                    if (i_stat.empty) begin
                        r_status <= chsd_pkg::ST_EMPTY;
                    end else begin
                        r_fid   <= i_found.id;
                        r_faddr <= i_found.addr;
                        r_fport <= i_found.port;
                    end
                end
                default: r_removed <= i_removed;
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/consistent_hash_shard_directory.sv */
// Top level: consistent-hash shard directory with stream ports and config port.
//
//  channel | dir | tdata / fields (low bit first)
//  s_axis  | in  | operation, shard_id, shard_addr, shard_port, key_hash, now
//  m_axis  | out | status, found_id, found_addr, found_port, removed_count
//  cfg     | in  | index 0 max_entries, 1 lifetime
//
// Each request is executed in the cycle it transfers; the result is registered and
// shown the next cycle. A new request transfers as the held result is taken, so one
// item per cycle under no stall; the parallel compare over all cells sets the path.
// Synchronous active-low reset empties the table and restores config defaults.
`timescale 1ns / 1ps
`default_nettype none
module consistent_hash_shard_directory #(
    parameter int CAPACITY = 128
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [1:0] operation, [32:2] shard_id, [64:33] shard_addr, [80:65] shard_port,
    // [111:81] key_hash, [143:112] now
    input  wire logic [143:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [1:0] status, [32:2] found_id, [64:33] found_addr, [80:65] found_port,
    // [88:81] removed_count
    output logic [95:0]       m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [0:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data
);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [7:0]  r_max_entries;
    logic [15:0] r_lifetime;
    logic [CW-1:0] limit;
    logic [32:0] exp_sum;
    logic [31:0] expiry;

    chsd_pkg::t_cmd   cmd;
    chsd_pkg::t_stat  stat;
    chsd_pkg::t_entry found;
    logic [7:0]       removed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= 8'd128;
            r_lifetime    <= 16'd15;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                chsd_pkg::CFG_MAX_ENTRIES: r_max_entries <= i_cfg_data[7:0];
                default:                   r_lifetime    <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        if (32'(r_max_entries) > 32'(CAPACITY))
            limit = CW'(CAPACITY);
        else
            limit = CW'(r_max_entries);
        exp_sum = {1'b0, s_axis_tdata[143:112]} + {17'd0, r_lifetime};
        expiry  = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
    end

    chsd_datapath #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_id     (s_axis_tdata[32:2]),
        .i_addr   (s_axis_tdata[64:33]),
        .i_port   (s_axis_tdata[80:65]),
        .i_key    (s_axis_tdata[111:81]),
        .i_now    (s_axis_tdata[143:112]),
        .i_expiry (expiry),
        .i_limit  (limit),
        .o_stat   (stat),
        .o_found  (found),
        .o_removed(removed)
    );

    assign m_axis_tdata[95:89] = '0;

    chsd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(s_axis_tvalid),
        .o_req_ready(s_axis_tready),
        .i_op       (s_axis_tdata[1:0]),
        .i_stat     (stat),
        .i_found    (found),
        .i_removed  (removed),
        .o_cmd      (cmd),
        .o_res_valid(m_axis_tvalid),
        .i_res_ready(m_axis_tready),
        .o_status   (m_axis_tdata[1:0]),
        .o_fid      (m_axis_tdata[32:2]),
        .o_faddr    (m_axis_tdata[64:33]),
        .o_fport    (m_axis_tdata[80:65]),
        .o_removed  (m_axis_tdata[88:81])
    );
endmodule
`default_nettype wire
